// ----- rtl/rssd_pkg.sv -----
// Package for the range sensor stuck detector.
// Holds register codes, reset values, default parameters and the lane config type.
// No dependencies.
package rssd_pkg;

   localparam int SENSOR_COUNT_DEFAULT  = 5;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int SAMPLE_W   = 8;
   localparam int NEAR_W     = 8;
   localparam int RANGE_W    = 9;
   localparam int RUN_W      = 16;
   localparam int VOTE_W     = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [NEAR_W-1:0]  NEAR_RESET  = 8'd5;
   localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd90;
   localparam logic [RUN_W-1:0]   RUN_RESET   = 16'd1000;
   localparam logic [VOTE_W-1:0]  VOTE_RESET  = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_NEAR_THRESHOLD = 3'd0,
      REG_RANGE_LIMIT    = 3'd1,
      REG_RUN_LIMIT      = 3'd2,
      REG_VOTE_MINIMUM   = 3'd3
   } reg_index_type;

   typedef struct packed {
      logic [NEAR_W-1:0]  near_threshold;
      logic [RANGE_W-1:0] range_limit;
      logic [RUN_W-1:0]   run_limit;
   } lane_cfg_type;

endpackage

// ----- rtl/rssd_lane.sv -----
// One sensor lane: moving average, run counter and registered vote flag.
// Depends on rssd_pkg.
module rssd_lane #(
   parameter int FRACTION_BITS = rssd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [rssd_pkg::SAMPLE_W-1:0]       sample,
   input  rssd_pkg::lane_cfg_type              cfg,
   output logic                                vote
);

   localparam int AVG_W = rssd_pkg::SAMPLE_W + FRACTION_BITS;

   logic [AVG_W-1:0]           avg_ff, avg_in;
   logic [rssd_pkg::RUN_W-1:0] count_ff, count_in;
   logic                       vote_ff, vote_in;

   logic [AVG_W-1:0] scaled;
   logic [AVG_W+6:0] weighted;
   logic [AVG_W+7:0] sum;
   logic [AVG_W-1:0] diff;
   logic [AVG_W-1:0] near_scaled;
   logic             still;

   always_comb begin
      scaled      = {sample, {FRACTION_BITS{1'b0}}};
      near_scaled = {cfg.near_threshold, {FRACTION_BITS{1'b0}}};
      weighted    = {avg_ff, 7'b0} - {7'b0, avg_ff};
      sum         = {1'b0, weighted} + {8'b0, scaled};
      avg_in      = sum[AVG_W+6:7];
      diff        = (avg_in >= scaled) ? (avg_in - scaled) : (scaled - avg_in);
      still       = ({1'b0, sample} < cfg.range_limit) && (diff < near_scaled);
      if (!still) begin
         count_in = '0;
      end else if (count_ff != '1) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
      vote_in = count_in > cfg.run_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff   <= '0;
         count_ff <= '0;
         vote_ff  <= 1'b0;
      end else if (accept) begin
         avg_ff   <= avg_in;
         count_ff <= count_in;
         vote_ff  <= vote_in;
      end
   end

   assign vote = vote_ff;

endmodule

// ----- rtl/rssd_merge.sv -----
// Merge stage: counts lane votes, compares with the vote minimum, holds the result.
// Depends on rssd_pkg.
module rssd_merge #(
   parameter int SENSOR_COUNT = rssd_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [SENSOR_COUNT-1:0]           votes,
   input  logic [rssd_pkg::VOTE_W-1:0]       vote_minimum,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              stuck,
   output logic [rssd_pkg::VOTE_W-1:0]       voting_sensors
);

   localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
   localparam int CMP_W = (CNT_W > rssd_pkg::VOTE_W) ? CNT_W : rssd_pkg::VOTE_W;

   logic [CNT_W-1:0]            count;
   logic                        valid_ff, valid_in;
   logic                        stuck_ff, stuck_in;
   logic [rssd_pkg::VOTE_W-1:0] voters_ff, voters_in;

   always_comb begin
      count = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         count = count + CNT_W'(votes[i]);
      end
      stuck_in  = CMP_W'(count) > CMP_W'(vote_minimum);
      voters_in = rssd_pkg::VOTE_W'(count);
      in_ready  = !valid_ff || out_ready;
      valid_in  = in_valid || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stuck_ff  <= stuck_in;
         voters_ff <= voters_in;
      end
   end

   assign out_valid      = valid_ff;
   assign stuck          = stuck_ff;
   assign voting_sensors = voters_ff;

endmodule

// ----- rtl/range_sensor_stuck_detector_core.sv -----
// Range sensor stuck detector: one lane per sensor updates its 1/128 moving average and
// run counter, then a merge stage counts sensors over the run limit and raises stuck when
// that count exceeds the vote minimum. One transaction is taken every clock cycle unless the
// response side stalls; each result is registered first in the lane registers and then in the
// result register. The lane state updates on each accepted transaction, so throughput is one
// transaction per cycle while the response side keeps taking results.
module range_sensor_stuck_detector_core #(
   parameter int SENSOR_COUNT  = rssd_pkg::SENSOR_COUNT_DEFAULT,
   parameter int FRACTION_BITS = rssd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // left_range, front_left_range, front_range, front_right_range, right_range (8 bits each)
   input  logic [SENSOR_COUNT*rssd_pkg::SAMPLE_W-1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // stuck [0], voting_sensors [3:1], zero [7:4]
   output logic [rssd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  logic                                     csr_write_enable,
   input  logic [rssd_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [rssd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   logic [rssd_pkg::NEAR_W-1:0]  near_ff;
   logic [rssd_pkg::RANGE_W-1:0] range_ff;
   logic [rssd_pkg::RUN_W-1:0]   run_ff;
   logic [rssd_pkg::VOTE_W-1:0]  vote_min_ff;

   rssd_pkg::lane_cfg_type       lane_cfg;
   logic [SENSOR_COUNT-1:0]      votes;
   logic                         stage_valid_ff, stage_valid_in;
   logic                         merge_ready;
   logic                         req_accept;
   logic                         stuck;
   logic [rssd_pkg::VOTE_W-1:0]  voting_sensors;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff     <= rssd_pkg::NEAR_RESET;
         range_ff    <= rssd_pkg::RANGE_RESET;
         run_ff      <= rssd_pkg::RUN_RESET;
         vote_min_ff <= rssd_pkg::VOTE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rssd_pkg::REG_NEAR_THRESHOLD: near_ff  <= csr_wdata[rssd_pkg::NEAR_W-1:0];
            rssd_pkg::REG_RANGE_LIMIT:    range_ff <= csr_wdata[rssd_pkg::RANGE_W-1:0];
            rssd_pkg::REG_RUN_LIMIT:      run_ff   <= csr_wdata[rssd_pkg::RUN_W-1:0];
            rssd_pkg::REG_VOTE_MINIMUM:   vote_min_ff <= csr_wdata[rssd_pkg::VOTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lane_cfg.near_threshold = near_ff;
      lane_cfg.range_limit    = range_ff;
      lane_cfg.run_limit      = run_ff;
      req_tready     = !stage_valid_ff || merge_ready;
      req_accept     = req_tvalid && req_tready;
      stage_valid_in = req_accept || (stage_valid_ff && !merge_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
      rssd_lane #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (req_accept),
         .sample (req_tdata[g*rssd_pkg::SAMPLE_W +: rssd_pkg::SAMPLE_W]),
         .cfg    (lane_cfg),
         .vote   (votes[g])
      );
   end

   rssd_merge #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid_ff),
      .in_ready       (merge_ready),
      .votes          (votes),
      .vote_minimum   (vote_min_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .stuck          (stuck),
      .voting_sensors (voting_sensors)
   );

   assign rsp_tdata = {{(rssd_pkg::RSP_DATA_W - rssd_pkg::VOTE_W - 1){1'b0}},
                       voting_sensors, stuck};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (stage_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("request side stalled while pipeline has room");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stage_valid_ff)
      else $error("accepted transaction did not reach the lane stage");

   a_voter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || (rsp_tdata[3:1] != 3'd0)))
      else $error("stuck reported with no voting sensors");

endmodule

// ----- verif/range_sensor_stuck_detector_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for range_sensor_stuck_detector_core: streams sample sets under random
// backpressure and checks every vote result against an in-bench moving-average predictor.
// Depends on rssd_pkg and the core RTL.

localparam int SAMPLE_W    = rssd_pkg::SAMPLE_W;
localparam int NEAR_W      = rssd_pkg::NEAR_W;
localparam int RANGE_W     = rssd_pkg::RANGE_W;
localparam int RUN_W       = rssd_pkg::RUN_W;
localparam int VOTE_W      = rssd_pkg::VOTE_W;
localparam int CSR_INDEX_W = rssd_pkg::CSR_INDEX_W;
localparam int CSR_DATA_W  = rssd_pkg::CSR_DATA_W;
localparam int RSP_DATA_W  = rssd_pkg::RSP_DATA_W;

localparam int SENSORS        = rssd_pkg::SENSOR_COUNT_DEFAULT;
localparam int FRAC_BITS      = rssd_pkg::FRACTION_BITS_DEFAULT;
localparam int AVG_W          = SAMPLE_W + FRAC_BITS;
localparam int AVERAGE_WEIGHT = 127;
localparam int AVERAGE_SHIFT  = 7;
localparam int MAX_REPORTS    = 10;
localparam logic [RUN_W-1:0] COUNTER_MAX = '1;

typedef struct packed {
   logic [SAMPLE_W-1:0] right_range;
   logic [SAMPLE_W-1:0] front_right_range;
   logic [SAMPLE_W-1:0] front_range;
   logic [SAMPLE_W-1:0] front_left_range;
   logic [SAMPLE_W-1:0] left_range;
} sample_set_type;

typedef struct packed {
   logic [RSP_DATA_W-VOTE_W-2:0] pad;
   logic [VOTE_W-1:0]            voting_sensors;
   logic                         stuck;
} vote_result_type;

class stuck_vote_board;
   logic [AVG_W-1:0]   averages [SENSORS];
   logic [RUN_W-1:0]   run_counts [SENSORS];
   logic [NEAR_W-1:0]  near_threshold;
   logic [RANGE_W-1:0] range_limit;
   logic [RUN_W-1:0]   run_limit;
   logic [VOTE_W-1:0]  vote_minimum;
   vote_result_type    expected_votes [$];
   int                 mismatches;

   function new();
      near_threshold = rssd_pkg::NEAR_RESET;
      range_limit    = rssd_pkg::RANGE_RESET;
      run_limit      = rssd_pkg::RUN_RESET;
      vote_minimum   = rssd_pkg::VOTE_RESET;
      foreach (averages[i]) begin
         averages[i]   = '0;
         run_counts[i] = '0;
      end
      mismatches = 0;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         rssd_pkg::REG_NEAR_THRESHOLD: near_threshold = value[NEAR_W-1:0];
         rssd_pkg::REG_RANGE_LIMIT:    range_limit    = value[RANGE_W-1:0];
         rssd_pkg::REG_RUN_LIMIT:      run_limit      = value[RUN_W-1:0];
         rssd_pkg::REG_VOTE_MINIMUM:   vote_minimum   = value[VOTE_W-1:0];
         default: ;
      endcase
   endfunction

   function void note_samples(sample_set_type samples);
      logic [SENSORS*SAMPLE_W-1:0]    flat;
      logic [SAMPLE_W-1:0]            sample;
      logic [AVG_W-1:0]               scaled;
      logic [AVG_W-1:0]               diff;
      logic [AVG_W+AVERAGE_SHIFT:0]   mix;
      int                             voters;
      vote_result_type                vote;
      flat   = samples;
      voters = 0;
      for (int i = 0; i < SENSORS; i++) begin
         sample      = flat[i*SAMPLE_W +: SAMPLE_W];
         scaled      = AVG_W'(sample) << FRAC_BITS;
         mix         = averages[i] * AVERAGE_WEIGHT + scaled;
         averages[i] = mix[AVG_W+AVERAGE_SHIFT-1:AVERAGE_SHIFT];
         diff = (averages[i] >= scaled) ? averages[i] - scaled : scaled - averages[i];
         if ({1'b0, sample} < range_limit &&
             diff < (AVG_W'(near_threshold) << FRAC_BITS)) begin
            if (run_counts[i] != COUNTER_MAX) run_counts[i]++;
         end else begin
            run_counts[i] = '0;
         end
         if (run_counts[i] > run_limit) voters++;
      end
      vote.pad            = '0;
      vote.voting_sensors = voters[VOTE_W-1:0];
      vote.stuck          = (voters > vote_minimum);
      expected_votes.push_back(vote);
   endfunction

   function void check_result(vote_result_type got);
      vote_result_type want;
      if (expected_votes.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected vote result: stuck=%0d voting_sensors=%0d pad=%0h",
                     got.stuck, got.voting_sensors, got.pad);
         return;
      end
      want = expected_votes.pop_front();
      if (got.stuck !== want.stuck || got.voting_sensors !== want.voting_sensors ||
          got.pad !== want.pad) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display({"vote mismatch: expected stuck=%0d voting_sensors=%0d pad=%0h,",
                      " got stuck=%0d voting_sensors=%0d pad=%0h"},
                     want.stuck, want.voting_sensors, want.pad,
                     got.stuck, got.voting_sensors, got.pad);
      end
   endfunction

   function int pending();
      return expected_votes.size();
   endfunction
endclass

module range_sensor_stuck_detector_core_test;
   localparam int FIRST_UNMAPPED_INDEX = 4;
   localparam int LAST_CSR_INDEX       = 7;
   localparam int DRAIN_CYCLES         = 6;
   localparam int LONG_HOLD_CYCLES     = 300;
   localparam int RANDOM_PHASES        = 14;
   localparam int STEADY_ITEMS         = 60;
   localparam int SAMPLE_MAX           = (1 << SAMPLE_W) - 1;
   localparam logic [RANGE_W-1:0] RANGE_OPEN = RANGE_W'(1 << SAMPLE_W);

   typedef enum {SENSOR_STEADY, SENSOR_NOISY, SENSOR_GLITCHY} sensor_style_type;
   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // left_range, front_left_range, front_range, front_right_range, right_range (8 bits each)
   logic [SENSORS*SAMPLE_W-1:0]     req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // stuck [0], voting_sensors [3:1], zero [7:4]
   logic [RSP_DATA_W-1:0]           rsp_tdata;
   logic                            csr_write_enable;
   logic [CSR_INDEX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]           csr_wdata;

   stuck_vote_board  board = new();
   int               results_seen = 0;
   int               next_hold_at = 400;
   rx_mode_type      rx_mode = RX_ALWAYS;
   bit               sender_idles;
   int               gap_max;
   int               burst_left;
   int               sensor_base [SENSORS];
   sensor_style_type sensor_style [SENSORS];
   int               jitter;

   range_sensor_stuck_detector_core #(
      .SENSOR_COUNT  (SENSORS),
      .FRACTION_BITS (FRAC_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int rx_cycle;
      rsp_tready = 1'b0;
      rx_cycle   = 0;
      forever begin
         @(negedge clock);
         if (results_seen >= next_hold_at) begin
            // hold off long enough to back up the core and stall its input
            next_hold_at = next_hold_at * 12;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= ($urandom_range(0, 9) < 7);
               default:   rsp_tready <= ((rx_cycle % 7) >= 3);
            endcase
            rx_cycle++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(vote_result_type'(rsp_tdata));
         results_seen++;
      end
   end

   initial begin
      #5_000_000;
      $display("[range_sensor_stuck_detector_core] ERROR");
      $finish;
   end

   function automatic sample_set_type uniform_set(logic [SAMPLE_W-1:0] value);
      return {SENSORS{value}};
   endfunction

   function automatic sample_set_type make_samples();
      logic [SENSORS*SAMPLE_W-1:0] flat;
      int                          value;
      for (int i = 0; i < SENSORS; i++) begin
         value = sensor_base[i] + int'($urandom_range(0, 2 * jitter)) - jitter;
         if (sensor_style[i] == SENSOR_NOISY ||
             (sensor_style[i] == SENSOR_GLITCHY && $urandom_range(0, 9) == 0))
            value = $urandom_range(0, SAMPLE_MAX);
         if (value < 0) value = 0;
         if (value > SAMPLE_MAX) value = SAMPLE_MAX;
         flat[i*SAMPLE_W +: SAMPLE_W] = value[SAMPLE_W-1:0];
      end
      return flat;
   endfunction

   task automatic offer_set(input sample_set_type samples);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= samples;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_samples(samples);
      if (sender_idles) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, gap_max - 1)) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= value;
      @(posedge clock);
      board.write_register(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [NEAR_W-1:0] near_value,
                                 input logic [RANGE_W-1:0] range_value,
                                 input logic [RUN_W-1:0] run_value,
                                 input logic [VOTE_W-1:0] vote_value,
                                 input bit idles, input rx_mode_type mode);
      logic [CSR_DATA_W-1:0] spare;
      wait_drained();
      sender_idles = idles;
      gap_max      = $urandom_range(1, 8);
      burst_left   = 0;
      rx_mode      = mode;
      // unused upper bits of the write data must be dropped by the core
      spare = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      csr_write(rssd_pkg::REG_NEAR_THRESHOLD, {spare[CSR_DATA_W-1:NEAR_W], near_value});
      csr_write(rssd_pkg::REG_RANGE_LIMIT, {spare[CSR_DATA_W-1:RANGE_W], range_value});
      csr_write(rssd_pkg::REG_RUN_LIMIT, run_value);
      csr_write(rssd_pkg::REG_VOTE_MINIMUM, {spare[CSR_DATA_W-1:VOTE_W], vote_value});
   endtask

   initial begin
      logic [NEAR_W-1:0]  near_value;
      logic [RANGE_W-1:0] range_value;
      logic [RUN_W-1:0]   run_value;
      logic [VOTE_W-1:0]  vote_value;
      int                 pick;

      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      sender_idles     = 1'b0;
      gap_max          = 1;
      burst_left       = 0;
      jitter           = 0;
      foreach (sensor_base[i]) begin
         sensor_base[i]  = $urandom_range(0, SAMPLE_MAX);
         sensor_style[i] = SENSOR_STEADY;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, averages starting from zero
      repeat (3) offer_set(uniform_set(8'h00));
      offer_set(uniform_set(8'hFF));
      offer_set(uniform_set(8'h55));
      offer_set(uniform_set(8'hAA));
      offer_set(sample_set_type'(40'h00FF00FF00));
      offer_set(sample_set_type'(40'hFF00FF00FF));

      // range limit edge with everything near
      apply_settings(8'hFF, 9'd90, '0, '0, 1'b1, RX_RANDOM);
      repeat (2) offer_set(uniform_set(8'd89));
      offer_set(uniform_set(8'd90));
      offer_set(sample_set_type'(40'h5A595A595A));
      offer_set(uniform_set(8'd89));

      // every sensor votes but the vote minimum is out of reach
      apply_settings(8'hFF, RANGE_OPEN, '0, 3'd5, 1'b0, RX_PATTERN);
      repeat (2) offer_set(uniform_set(8'hFF));
      apply_settings(8'hFF, '1, '0, '1, 1'b0, RX_ALWAYS);
      offer_set(uniform_set(8'hFF));

      // zero near threshold keeps every counter cleared
      apply_settings('0, RANGE_OPEN, '0, '0, 1'b1, RX_ALWAYS);
      repeat (2) offer_set(uniform_set(8'h00));

      // top run limit: no counter can exceed it
      apply_settings(8'hFF, RANGE_OPEN, '1, '0, 1'b0, RX_RANDOM);
      repeat (2) offer_set(uniform_set(8'h00));
      wait_drained();
      csr_write(CSR_INDEX_W'($urandom_range(FIRST_UNMAPPED_INDEX, LAST_CSR_INDEX)), '1);
      offer_set(uniform_set(8'h00));

      // zero range limit: nothing is below it
      apply_settings(8'hFF, '0, '0, '0, 1'b0, RX_ALWAYS);
      offer_set(uniform_set(8'h00));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       near_value = '0;
            1:       near_value = '1;
            2, 3:    near_value = NEAR_W'($urandom_range(1, 40));
            default: near_value = NEAR_W'($urandom_range(0, SAMPLE_MAX));
         endcase
         case ($urandom_range(0, 5))
            0:       range_value = '0;
            1:       range_value = RANGE_OPEN;
            2:       range_value = '1;
            3:       range_value = RANGE_W'($urandom_range(0, RANGE_OPEN));
            default: range_value = RANGE_W'($urandom_range(0, (1 << RANGE_W) - 1));
         endcase
         case ($urandom_range(0, 9))
            0:       run_value = '0;
            1:       run_value = COUNTER_MAX - 1'b1;
            2:       run_value = COUNTER_MAX;
            3, 4:    run_value = RUN_W'($urandom_range(31, 200));
            default: run_value = RUN_W'($urandom_range(1, 30));
         endcase
         vote_value = ($urandom_range(0, 9) < 7) ? VOTE_W'($urandom_range(0, 3)) :
                                                   VOTE_W'($urandom_range(4, 7));
         for (int i = 0; i < SENSORS; i++) begin
            if ($urandom_range(0, 6) == 0) sensor_base[i] = $urandom_range(0, SAMPLE_MAX);
            pick = $urandom_range(0, 19);
            sensor_style[i] = (pick < 13) ? SENSOR_STEADY :
                              (pick < 16) ? SENSOR_NOISY : SENSOR_GLITCHY;
         end
         jitter = $urandom_range(0, 3);
         apply_settings(near_value, range_value, run_value, vote_value,
                        $urandom_range(0, 3) != 0, rx_mode_type'($urandom_range(0, 2)));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_INDEX_W'($urandom_range(FIRST_UNMAPPED_INDEX, LAST_CSR_INDEX)),
                      CSR_DATA_W'($urandom));
         repeat ($urandom_range(70, 120)) offer_set(make_samples());
      end

      // steady run against the top run limits
      foreach (sensor_style[i]) sensor_style[i] = SENSOR_STEADY;
      jitter = 0;
      apply_settings('1, RANGE_OPEN, COUNTER_MAX - 1'b1, 3'd4, 1'b0, RX_ALWAYS);
      repeat (STEADY_ITEMS) offer_set(make_samples());
      apply_settings('1, RANGE_OPEN, COUNTER_MAX, '0, 1'b1, RX_RANDOM);
      repeat (20) offer_set(make_samples());
      apply_settings('1, RANGE_OPEN, COUNTER_MAX - 1'b1, 3'd4, 1'b0, RX_PATTERN);
      repeat (5) offer_set(make_samples());
      apply_settings('1, RANGE_OPEN, COUNTER_MAX - 1'b1, 3'd5, 1'b1, RX_ALWAYS);
      repeat (3) offer_set(make_samples());

      wait_drained();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[range_sensor_stuck_detector_core] OK");
      end else begin
         $display("[range_sensor_stuck_detector_core] ERROR");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/rssd_pkg.sv
rtl/rssd_lane.sv
rtl/rssd_merge.sv
rtl/range_sensor_stuck_detector_core.sv
verif/range_sensor_stuck_detector_core_test.sv
